@@ rtl/core/kmf_pkg.sv @@
package kmf_pkg;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 32;

    localparam int CHAR_W = 8;
    localparam int SLOT_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int IDX_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [MAX_WORDS-1:0] wmask_t;

    typedef len_t   len_arr_t [MAX_WORDS];
    typedef wmask_t ok_arr_t  [MAX_WORD_LEN];

    localparam idx_t  IDX_LAST    = idx_t'(MAX_WORD_LEN - 1);
    localparam char_t MASK_RESET  = char_t'(42);

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_TEXT = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // keyword character write, broadcast to every cell
    typedef struct packed {
        logic  en;
        slot_t slot;
        idx_t  pos;
        char_t ch;
    } load_t;

    // window movement, broadcast to every cell
    typedef struct packed {
        logic  app;
        idx_t  app_idx;
        logic  feed;
        logic  shift;
        char_t ch;
    } step_t;

    // outcome of the head decision
    typedef struct packed {
        logic  hit;
        len_t  len;
        char_t mask;
    } decision_t;

    typedef struct packed {
        char_t plain;
        char_t shown;
        logic  last;
    } res_t;

endpackage

@@ rtl/core/kmf_cell.sv @@
module kmf_cell (
    input  logic              clk,
    input  kmf_pkg::idx_t     pos,
    input  kmf_pkg::load_t    load,
    input  kmf_pkg::step_t    step,
    input  kmf_pkg::len_arr_t lens,
    input  kmf_pkg::decision_t dec,
    input  kmf_pkg::char_t    nb_shown,
    input  kmf_pkg::char_t    nb_plain,
    output kmf_pkg::char_t    out_shown,
    output kmf_pkg::char_t    out_plain,
    output kmf_pkg::wmask_t   ok
);
    import kmf_pkg::*;

    char_t shown_reg;
    char_t plain_reg;
    char_t kw_reg [MAX_WORDS];
    char_t view_shown;
    char_t view_plain;
    logic  masked;

    // the tail cell sees the arriving character when the window pops on it
    always_comb
    begin
        if (step.feed && pos == IDX_LAST)
        begin
            view_shown = step.ch;
            view_plain = step.ch;
        end
        else
        begin
            view_shown = shown_reg;
            view_plain = plain_reg;
        end
    end

    // per slot: position beyond the keyword, or the character agrees
    always_comb
    begin
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            ok[w] = (len_t'(pos) >= lens[w]) || (view_shown == kw_reg[w]);
        end
    end

    assign masked    = dec.hit && (pos != '0) && (len_t'(pos) < dec.len);
    assign out_shown = masked ? dec.mask : view_shown;
    assign out_plain = view_plain;

    always_ff @(posedge clk)
    begin
        if (load.en && load.pos == pos)
        begin
            kw_reg[load.slot] <= load.ch;
        end
        if (step.shift)
        begin
            shown_reg <= nb_shown;
            plain_reg <= nb_plain;
        end
        else if (step.app && step.app_idx == pos)
        begin
            shown_reg <= step.ch;
            plain_reg <= step.ch;
        end
    end

endmodule

@@ rtl/core/kmf_match.sv @@
module kmf_match (
    input  kmf_pkg::ok_arr_t   ok_all,
    input  kmf_pkg::len_arr_t  lens,
    input  kmf_pkg::len_t      avail,
    input  kmf_pkg::char_t     mask,
    output kmf_pkg::decision_t dec
);
    import kmf_pkg::*;

    wmask_t all_ok;
    wmask_t cand;

    // AND each slot's verdict across the window
    always_comb
    begin
        all_ok = '1;
        for (int k = 0; k < MAX_WORD_LEN; k++)
        begin
            all_ok = all_ok & ok_all[k];
        end
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            cand[w] = all_ok[w] && (lens[w] >= len_t'(2)) && (lens[w] <= avail);
        end
    end

    // lowest slot wins
    always_comb
    begin
        dec.hit  = 1'b0;
        dec.len  = '0;
        dec.mask = mask;
        for (int w = MAX_WORDS - 1; w >= 0; w--)
        begin
            if (cand[w])
            begin
                dec.hit = 1'b1;
                dec.len = lens[w];
            end
        end
    end

endmodule

@@ rtl/core/kmf_obuf.sv @@
module kmf_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kmf_pkg::res_t push_data,
    input  logic          out_ready,
    output logic          out_valid,
    output kmf_pkg::res_t out_data,
    output logic          full
);
    import kmf_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

@@ rtl/core/keyword_masking_filter.sv @@
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | kind, word_slot, char_pos, char_value,
//           |                      | word_done
// result    | out_valid / out_ready| plain_char, shown_char, last
// mask reg  | mask_we              | mask_char
//
// One item per cycle while in_ready is high: text characters and keyword
// loads transfer back to back; the head decision is made by the cell row and
// one match reduction in the cycle the window pops. An end of text drains the
// window one character per cycle unless stalled; in_ready is low meanwhile.
// Reset clears the window fill, all keyword lengths, the output buffer and sets
// the mask to '*'; keyword characters are undefined until loaded.
// A two-entry output buffer keeps the input open while one result waits.
module keyword_masking_filter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     kind,
    input  logic [3:0]     word_slot,
    input  logic [4:0]     char_pos,
    input  logic [7:0]     char_value,
    input  logic           word_done,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     plain_char,
    output logic [7:0]     shown_char,
    output logic           last,
    input  logic           mask_we,
    input  logic [7:0]     mask_char
);
    import kmf_pkg::*;

    char_t     mask_reg;
    len_t      fill_reg;
    len_t      fill_next;
    logic      drain_reg;
    logic      drain_next;
    len_arr_t  len_reg;

    logic      accept;
    logic      load_ok;
    logic      is_text;
    logic      text_pop;
    logic      text_app;
    logic      drain_pop;
    logic      pop;
    logic      pop_last;
    logic      ob_full;
    len_t      avail;
    load_t     load;
    step_t     step;
    decision_t dec;
    ok_arr_t   ok_all;
    res_t      res;
    res_t      out_res;

    char_t shown_chain [MAX_WORD_LEN];
    char_t plain_chain [MAX_WORD_LEN];

    // take nothing while draining or while the skid stage is occupied
    assign in_ready = !drain_reg && !ob_full;
    assign accept   = in_valid && in_ready;

    assign load_ok = accept && (kind == KIND_LOAD)
                     && (32'(word_slot) < MAX_WORDS) && (32'(char_pos) < MAX_WORD_LEN);
    assign is_text  = accept && (kind == KIND_TEXT);
    assign text_pop = is_text && (fill_reg == len_t'(MAX_WORD_LEN - 1));
    assign text_app = is_text && !text_pop;
    assign drain_pop = drain_reg && !ob_full;
    assign pop       = text_pop || drain_pop;
    assign pop_last  = drain_pop && (fill_reg == len_t'(1));
    // a popping text item counts itself in the window
    assign avail     = text_pop ? len_t'(MAX_WORD_LEN) : fill_reg;

    assign load.en   = load_ok;
    assign load.slot = slot_t'(word_slot);
    assign load.pos  = idx_t'(char_pos);
    assign load.ch   = char_value;

    assign step.app     = text_app;
    assign step.app_idx = idx_t'(fill_reg);
    assign step.feed    = text_pop;
    assign step.shift   = pop;
    assign step.ch      = char_value;

    // window row: cell 0 is the head, each cell shifts toward it
    for (genvar k = 0; k < MAX_WORD_LEN; k++)
    begin : g_cell
        char_t nb_shown;
        char_t nb_plain;
        if (k == MAX_WORD_LEN - 1)
        begin : g_tail
            assign nb_shown = char_value;
            assign nb_plain = char_value;
        end
        else
        begin : g_body
            assign nb_shown = shown_chain[k+1];
            assign nb_plain = plain_chain[k+1];
        end
        kmf_cell u_cell (
            .clk       (clk),
            .pos       (idx_t'(k)),
            .load      (load),
            .step      (step),
            .lens      (len_reg),
            .dec       (dec),
            .nb_shown  (nb_shown),
            .nb_plain  (nb_plain),
            .out_shown (shown_chain[k]),
            .out_plain (plain_chain[k]),
            .ok        (ok_all[k])
        );
    end

    kmf_match u_match (
        .ok_all (ok_all),
        .lens   (len_reg),
        .avail  (avail),
        .mask   (mask_reg),
        .dec    (dec)
    );

    assign res.plain = plain_chain[0];
    assign res.shown = shown_chain[0];
    assign res.last  = pop_last;

    kmf_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pop),
        .push_data (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_res),
        .full      (ob_full)
    );

    assign plain_char = out_res.plain;
    assign shown_char = out_res.shown;
    assign last       = out_res.last;

    // advance fill on append, drop one per drained character
    always_comb
    begin
        fill_next  = fill_reg;
        drain_next = drain_reg;
        if (text_app)
        begin
            fill_next = fill_reg + len_t'(1);
        end
        else if (drain_pop)
        begin
            fill_next = fill_reg - len_t'(1);
        end
        if (accept && kind == KIND_END && fill_reg != '0)
        begin
            drain_next = 1'b1;
        end
        else if (pop_last)
        begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            drain_reg <= 1'b0;
            mask_reg  <= MASK_RESET;
            for (int w = 0; w < MAX_WORDS; w++)
            begin
                len_reg[w] <= '0;
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
            if (mask_we)
            begin
                mask_reg <= mask_char;
            end
            if (load_ok && word_done)
            begin
                len_reg[slot_t'(word_slot)] <= len_t'(char_pos) + len_t'(1);
            end
        end
    end

endmodule

@@ tb/keyword_masking_filter_tb.sv @@
`timescale 1ns / 100ps

module keyword_masking_filter_tb;

    import kmf_pkg::*;

    // Item kind that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Base letter of most text and keyword characters, so matches are common.
    localparam char_t LETTER_A = 8'h61;

    // One input transfer, field by field.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] slot;
        logic [4:0] pos;
        char_t      ch;
        logic       done;
    } censor_item_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] kind       = '0;
    logic [3:0] word_slot  = '0;
    logic [4:0] char_pos   = '0;
    logic [7:0] char_value = '0;
    logic       word_done  = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] plain_char;
    logic [7:0] shown_char;
    logic       last;
    logic       mask_we    = 1'b0;
    logic [7:0] mask_char  = MASK_RESET;

    keyword_masking_filter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .word_slot  (word_slot),
        .char_pos   (char_pos),
        .char_value (char_value),
        .word_done  (word_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .plain_char (plain_char),
        .shown_char (shown_char),
        .last       (last),
        .mask_we    (mask_we),
        .mask_char  (mask_char)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Censor predictor: its own keyword table, window and mask register.
    // ------------------------------------------------------------------
    char_t kw_tab [MAX_WORDS][MAX_WORD_LEN];
    len_t  kw_len [MAX_WORDS];
    char_t win_plain [MAX_WORD_LEN];
    char_t win_shown [MAX_WORD_LEN];
    int    win_fill = 0;
    char_t mask_now = MASK_RESET;

    // Results the block still owes, oldest first.
    res_t  censored_q [$];

    // Items waiting for the driver, filled by the stimulus block.
    censor_item_t item_q [$];

    // Generator view of which keyword positions have been loaded, so that a
    // keyword length never covers a character that was never written.
    logic [MAX_WORD_LEN-1:0] kw_written [MAX_WORDS];

    int    mismatches = 0;
    int    n_items    = 0;
    bit    calm       = 1'b0;   // no idling on either side while set

    initial begin
        for (int s = 0; s < MAX_WORDS; s++)
        begin
            kw_len[s]     = '0;
            kw_written[s] = '0;
        end
    end

    // Mask the keyword span behind the head, if any keyword matches within avail chars.
    function automatic void mask_at_head(int avail);
        int w, k, len;
        bit hit;
        for (w = 0; w < MAX_WORDS; w++)
        begin
            len = kw_len[w];
            if (len < 2 || len > avail)
                continue;
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (win_shown[k] != kw_tab[w][k])
                    hit = 1'b0;
            if (hit)
            begin
                for (k = 1; k < len; k++)
                    win_shown[k] = mask_now;
                return;
            end
        end
    endfunction

    // Emit the head as an expected result and advance the window.
    function automatic void pop_head(bit is_last);
        res_t r;
        r.plain = win_plain[0];
        r.shown = win_shown[0];
        r.last  = is_last;
        censored_q.push_back(r);
        for (int i = 0; i < win_fill - 1; i++)
        begin
            win_plain[i] = win_plain[i+1];
            win_shown[i] = win_shown[i+1];
        end
        win_fill--;
    endfunction

    function automatic void censor_item(censor_item_t it);
        case (it.kind)
            KIND_LOAD:
            begin
                kw_tab[it.slot][it.pos] = it.ch;
                if (it.done)
                    kw_len[it.slot] = len_t'(it.pos) + len_t'(1);
            end
            KIND_TEXT:
            begin
                if (win_fill < MAX_WORD_LEN)
                begin
                    win_plain[win_fill] = it.ch;
                    win_shown[win_fill] = it.ch;
                    win_fill++;
                end
                if (win_fill >= MAX_WORD_LEN)
                begin
                    mask_at_head(win_fill);
                    pop_head(1'b0);
                end
            end
            KIND_END:
            begin
                while (win_fill > 0)
                begin
                    mask_at_head(win_fill);
                    pop_head(win_fill == 1);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued items, predict on every accepted transfer.
    // ------------------------------------------------------------------
    censor_item_t drv_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                censor_item(drv_item);
            // Hold the payload until the transfer; only then pick the next one.
            if (!in_valid || in_ready)
            begin
                if (item_q.size() != 0 && (calm || $urandom_range(99) >= 28))
                begin
                    drv_item    = item_q.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= drv_item.kind;
                    word_slot  <= drv_item.slot;
                    char_pos   <= drv_item.pos;
                    char_value <= drv_item.ch;
                    word_done  <= drv_item.done;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation.
    // ------------------------------------------------------------------
    res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (censored_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result plain=%h shown=%h last=%b",
                                 $realtime, plain_char, shown_char, last);
                end
                else
                begin
                    want = censored_q.pop_front();
                    if (plain_char !== want.plain || shown_char !== want.shown ||
                        last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: plain/shown/last expected %h/%h/%b, got %h/%h/%b",
                                     $realtime, want.plain, want.shown, want.last,
                                     plain_char, shown_char, last);
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(logic [1:0] k, logic [3:0] s, logic [4:0] p,
                                      char_t c, logic d);
        censor_item_t it;
        it.kind = k;
        it.slot = s;
        it.pos  = p;
        it.ch   = c;
        it.done = d;
        item_q.push_back(it);
        if (k == KIND_LOAD)
            kw_written[s][p] = 1'b1;
        if (k != KIND_UNUSED)
            n_items++;
    endfunction

    // Mostly a, b or c; sometimes any byte.
    function automatic char_t pick_char();
        if ($urandom_range(99) < 80)
            return LETTER_A + char_t'($urandom_range(2));
        return char_t'($urandom_range(255));
    endfunction

    // Load a keyword; the length-setting character goes last.
    function automatic void add_word(logic [3:0] s, int len);
        for (int p = 0; p < len; p++)
            push_item(KIND_LOAD, s, p[4:0], pick_char(), p == len - 1);
    endfunction

    // Wait until nothing is pending or owed, plus a margin for silent items.
    task automatic wait_idle();
        do
        begin
            while (item_q.size() != 0 || in_valid || censored_q.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
        while (item_q.size() != 0 || in_valid || censored_q.size() != 0);
    endtask

    task automatic set_mask(char_t v);
        @(posedge clk);
        mask_we   <= 1'b1;
        mask_char <= v;
        @(posedge clk);
        mask_we   <= 1'b0;
        mask_now   = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase, n_words, text_len, r, sl, ps;
        bit ok;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: end on an empty window, an unknown kind with all bits set.
        push_item(KIND_END, 4'd0, 5'd0, 8'h00, 1'b0);
        push_item(KIND_UNUSED, 4'd15, 5'd31, 8'hff, 1'b1);
        // Length-one keyword that must never match; last slot, last position.
        push_item(KIND_LOAD, 4'd15, 5'd0, "x", 1'b1);
        push_item(KIND_LOAD, 4'd15, 5'd31, 8'h00, 1'b0);
        // "ab" in slot 0 wins over "abc" in slot 1.
        push_item(KIND_LOAD, 4'd0, 5'd0, "a", 1'b0);
        push_item(KIND_LOAD, 4'd0, 5'd1, "b", 1'b1);
        push_item(KIND_LOAD, 4'd1, 5'd0, "a", 1'b0);
        push_item(KIND_LOAD, 4'd1, 5'd1, "b", 1'b0);
        push_item(KIND_LOAD, 4'd1, 5'd2, "c", 1'b1);
        // Keyword of extreme byte values.
        push_item(KIND_LOAD, 4'd2, 5'd0, 8'hff, 1'b0);
        push_item(KIND_LOAD, 4'd2, 5'd1, 8'h00, 1'b1);
        push_item(KIND_TEXT, 4'd15, 5'd31, "x", 1'b1);
        push_item(KIND_TEXT, 4'd0, 5'd0, "a", 1'b0);
        push_item(KIND_TEXT, 4'd0, 5'd0, "b", 1'b0);
        push_item(KIND_TEXT, 4'd0, 5'd0, "c", 1'b0);
        push_item(KIND_TEXT, 4'd0, 5'd0, 8'hff, 1'b0);
        push_item(KIND_TEXT, 4'd0, 5'd0, 8'h00, 1'b0);
        push_item(KIND_TEXT, 4'd0, 5'd0, "b", 1'b0);
        // A trailing "a" cannot match "ab": the keyword runs past the end of text.
        push_item(KIND_TEXT, 4'd0, 5'd0, "a", 1'b0);
        push_item(KIND_END, 4'd15, 5'd31, 8'hff, 1'b1);

        n_items = 0;
        phase   = 0;
        while (n_items < 200)
        begin
            wait_idle();
            case (phase)
                0:       set_mask(8'h00);
                1:       set_mask(8'hff);
                2:       set_mask(LETTER_A);   // masked text can itself match
                default: set_mask(char_t'($urandom_range(255)));
            endcase
            calm = (phase == 3);

            n_words = $urandom_range(1, 3);
            for (int w = 0; w < n_words; w++)
                add_word(4'($urandom_range(15)),
                         ($urandom_range(99) < 8) ? $urandom_range(1, 32)
                                                  : $urandom_range(2, 4));

            // Phases 4 and 7 run long enough for the window to fill and pop on text.
            text_len = (phase == 4 || phase == 7) ? $urandom_range(60, 80)
                                                  : $urandom_range(0, 40);
            for (int i = 0; i < text_len; i++)
            begin
                r = $urandom_range(99);
                if (r < 4)
                begin
                    push_item(KIND_UNUSED, 4'($urandom_range(15)), 5'($urandom_range(31)),
                              char_t'($urandom_range(255)), 1'($urandom_range(1)));
                end
                else if (r < 9)
                begin
                    // Keyword change mid-text; set a length only over loaded positions.
                    sl = $urandom_range(15);
                    ps = $urandom_range(31);
                    ok = 1'b1;
                    for (int p = 0; p < ps; p++)
                        if (!kw_written[sl][p])
                            ok = 1'b0;
                    push_item(KIND_LOAD, sl[3:0], ps[4:0], pick_char(),
                              ok && $urandom_range(1));
                end
                else
                begin
                    push_item(KIND_TEXT, 4'($urandom_range(15)), 5'($urandom_range(31)),
                              pick_char(), 1'($urandom_range(1)));
                end
            end
            push_item(KIND_END, 4'($urandom_range(15)), 5'($urandom_range(31)),
                      char_t'($urandom_range(255)), 1'($urandom_range(1)));
            phase++;
        end

        calm = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && censored_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Drop the run if the block stops making progress.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ keyword_masking_filter.f @@
rtl/core/kmf_pkg.sv
rtl/core/kmf_cell.sv
rtl/core/kmf_match.sv
rtl/core/kmf_obuf.sv
rtl/core/keyword_masking_filter.sv
tb/keyword_masking_filter_tb.sv
